FILE: design/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge out of reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: design/yz_pkg.sv
// package with shared types and constants of the yaz0 decompressor
package yz_pkg;

    localparam int WINDOW_BYTES = 4096;
    localparam int WIN_AW = $clog2(WINDOW_BYTES);
    localparam logic [31:0] MAX_OUTPUT_BYTES_DEF = 32'd16777216;

    localparam logic [3:0] LEN_SHORT_BIAS = 4'h2;
    localparam logic [8:0] LEN_LONG_BIAS = 9'h012;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_CAP_EN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAP = 2'd1;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_BAD_MAGIC = 2'd1;
    localparam logic [1:0] ST_SIZE_BIG = 2'd2;
    localparam logic [1:0] ST_OFFSET = 2'd3;

    typedef enum logic [3:0] {
        PH_MAGIC,
        PH_SIZE,
        PH_RESERVED,
        PH_GROUP,
        PH_LITERAL,
        PH_REF1,
        PH_REF2,
        PH_REF3,
        PH_DONE,
        PH_ERR_MAGIC,
        PH_ERR_SIZE,
        PH_ERR_OFFSET
    } phase_t;

    typedef enum logic [1:0] {
        E_IDLE,
        E_RD,
        E_WR,
        E_EMIT
    } eng_t;

    typedef struct packed {
        logic              wr_en;
        logic [WIN_AW-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              rd_en;
        logic [WIN_AW-1:0] rd_addr;
    } mem_req_t;

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] m;
        case (idx)
            2'd0: m = 8'h59;
            2'd1: m = 8'h61;
            2'd2: m = 8'h7A;
            default: m = 8'h30;
        endcase
        return m;
    endfunction

endpackage

FILE: design/yz_if.sv
// stream and configuration channel interfaces
interface yz_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_first;
    modport source (output valid, in_byte, in_first, input ready);
    modport sink (input valid, in_byte, in_first, output ready);
endinterface

interface yz_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] out_data;
    logic [3:0]  out_count;
    logic        out_last;
    logic        out_done;
    logic [1:0]  out_status;
    modport source (output valid, out_data, out_count, out_last, out_done, out_status,
                    input ready);
    modport sink (input valid, out_data, out_count, out_last, out_done, out_status,
                  output ready);
endinterface

interface yz_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [yz_pkg::CFG_IDX_W-1:0] index;
    logic [30:0]                  data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: design/yaz0_decompressor.sv
// top level of the yaz0 stream decompressor
//
//  channel  dir  words
//  strm     in   compressed byte + first-of-stream flag
//  dec      out  up to eight decoded bytes, count, last, done, status
//  cfg      in   register index + write data (0 cap enable, 1 cap)
//
//  header, group, literal and error bytes: accept step, then output register in the emit step
//  back-references: a history read then a write-back for each copied byte
//  plus an emit step after every eight copied bytes and after the last, length up to 273
//  reset clears control only; the history needs no clearing since a
//  reference can never reach before the start of the current stream
//  a stalled output holds the engine in its emit step; input waits meanwhile
module yaz0_decompressor #(
    parameter logic [31:0] MAX_OUTPUT_BYTES = yz_pkg::MAX_OUTPUT_BYTES_DEF
) (
    input logic      clk,
    input logic      rst_n,
    yz_in_if.sink    strm,
    yz_out_if.source dec,
    yz_cfg_if.sink   cfg
);

    // request from the sequencer to the history memory
    yz_pkg::mem_req_t mreq;
    // registered read byte, valid in the cycle after the read request
    logic [7:0]       rd_data;

    // parse state machine, copy engine and output register
    yz_ctrl #(
        .MAX_OUTPUT_BYTES(MAX_OUTPUT_BYTES)
    ) u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .strm(strm),
        .dec(dec),
        .cfg(cfg),
        .mreq(mreq),
        .rd_data(rd_data)
    );

    // 4 KiB history window, indexed by output position modulo the window
    yz_history u_hist (
        .clk(clk),
        .req(mreq),
        .rd_data(rd_data)
    );

endmodule

FILE: design/yz_history.sv
// history window memory, one write and one registered read per cycle
module yz_history (
    input  logic             clk,
    input  yz_pkg::mem_req_t req,
    output logic [7:0]       rd_data
);

    logic [7:0] mem [yz_pkg::WINDOW_BYTES];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

FILE: design/yz_ctrl.sv
// parse sequencer, copy engine and output register
module yz_ctrl #(
    parameter logic [31:0] MAX_OUTPUT_BYTES = yz_pkg::MAX_OUTPUT_BYTES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    yz_in_if.sink            strm,
    yz_out_if.source         dec,
    yz_cfg_if.sink           cfg,
    output yz_pkg::mem_req_t mreq,
    input  logic [7:0]       rd_data
);

    typedef struct packed {
        yz_pkg::phase_t ph;
        logic [7:0]     gb;
        logic [3:0]     gl;
    } ni_t;

    function automatic ni_t next_item(input logic [31:0] ps, input logic [31:0] ds,
                                      input logic [7:0] gb, input logic [3:0] gl);
        ni_t r;
        r.gb = gb;
        r.gl = gl;
        if (ps >= ds)
        begin
            r.ph = yz_pkg::PH_DONE;
        end
        else if (gl == 4'd0)
        begin
            r.ph = yz_pkg::PH_GROUP;
        end
        else
        begin
            r.ph = gb[7] ? yz_pkg::PH_LITERAL : yz_pkg::PH_REF1;
            r.gb = {gb[6:0], 1'b0};
            r.gl = gl - 4'd1;
        end
        return r;
    endfunction

    yz_pkg::eng_t   eng_reg, eng_next;
    yz_pkg::phase_t ph_reg, ph_next;
    logic [3:0]  pc_reg, pc_next;
    logic [31:0] ds_reg, ds_next;
    logic [31:0] ps_reg, ps_next;
    logic [7:0]  gb_reg, gb_next;
    logic [3:0]  gl_reg, gl_next;
    logic [7:0]  r1_reg, r1_next;
    logic [7:0]  r2_reg, r2_next;
    logic [8:0]  left_reg, left_next;
    logic [12:0] off_reg, off_next;
    logic [63:0] pack_reg, pack_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        last_reg, last_next;
    logic        done_reg, done_next;
    logic [1:0]  st_reg, st_next;
    logic        cap_en_reg;
    logic [30:0] cap_reg;
    logic        ov_reg, ov_next;
    logic [63:0] od_reg, od_next;
    logic [3:0]  oc_reg, oc_next;
    logic        ol_reg, ol_next;
    logic        odn_reg, odn_next;
    logic [1:0]  os_reg, os_next;

    logic in_acc;
    logic out_free;
    logic fin;

    assign in_acc = strm.valid && strm.ready;
    assign out_free = !ov_reg || dec.ready;
    assign fin = (left_reg == 9'd1) || (ps_reg + 32'd1 >= ds_reg);

    assign strm.ready = (eng_reg == yz_pkg::E_IDLE);
    assign cfg.ready = 1'b1;
    assign dec.valid = ov_reg;
    assign dec.out_data = od_reg;
    assign dec.out_count = oc_reg;
    assign dec.out_last = ol_reg;
    assign dec.out_done = odn_reg;
    assign dec.out_status = os_reg;

    // engine sequencing
    always_comb
    begin
        eng_next = eng_reg;
        case (eng_reg)
            yz_pkg::E_IDLE:
            begin
                if (in_acc)
                begin
                    eng_next = yz_pkg::E_EMIT;
                    if (((ph_next == yz_pkg::PH_REF2) || (ph_next == yz_pkg::PH_REF3))
                        && (left_next != 9'd0) && (eng_reg == yz_pkg::E_IDLE)
                        && (st_next == yz_pkg::ST_OK) && (cnt_next == 4'd0)
                        && !last_next)
                    begin
                        eng_next = yz_pkg::E_RD;
                    end
                end
            end
            yz_pkg::E_RD:
            begin
                eng_next = yz_pkg::E_WR;
            end
            yz_pkg::E_WR:
            begin
                if (fin || (cnt_reg == 4'd7))
                begin
                    eng_next = yz_pkg::E_EMIT;
                end
                else
                begin
                    eng_next = yz_pkg::E_RD;
                end
            end
            yz_pkg::E_EMIT:
            begin
                if (out_free)
                begin
                    eng_next = last_reg ? yz_pkg::E_IDLE : yz_pkg::E_RD;
                end
            end
            default:
            begin
                eng_next = yz_pkg::E_IDLE;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        logic [8:0]  len;
        logic [12:0] off;
        logic        copy;
        ni_t         ni;
        ph_next = ph_reg;
        pc_next = pc_reg;
        ds_next = ds_reg;
        ps_next = ps_reg;
        gb_next = gb_reg;
        gl_next = gl_reg;
        r1_next = r1_reg;
        r2_next = r2_reg;
        left_next = left_reg;
        off_next = off_reg;
        pack_next = pack_reg;
        cnt_next = cnt_reg;
        last_next = last_reg;
        done_next = done_reg;
        st_next = st_reg;
        ov_next = ov_reg && !dec.ready;
        od_next = od_reg;
        oc_next = oc_reg;
        ol_next = ol_reg;
        odn_next = odn_reg;
        os_next = os_reg;
        mreq = '0;
        len = 9'd0;
        off = 13'd0;
        copy = 1'b0;
        ni = '0;
        case (eng_reg)
            yz_pkg::E_IDLE:
            begin
                if (in_acc)
                begin
                    if (strm.in_first)
                    begin
                        ph_next = yz_pkg::PH_MAGIC;
                        pc_next = 4'd0;
                        ds_next = 32'd0;
                        ps_next = 32'd0;
                        gb_next = 8'd0;
                        gl_next = 4'd0;
                        r1_next = 8'd0;
                        r2_next = 8'd0;
                    end
                    pack_next = 64'd0;
                    cnt_next = 4'd0;
                    last_next = 1'b1;
                    left_next = 9'd0;
                    case (ph_next)
                        yz_pkg::PH_MAGIC:
                        begin
                            if (strm.in_byte != yz_pkg::magic_byte(pc_next[1:0]))
                            begin
                                ph_next = yz_pkg::PH_ERR_MAGIC;
                            end
                            else
                            begin
                                pc_next = pc_next + 4'd1;
                                if (pc_next == 4'd4)
                                begin
                                    ph_next = yz_pkg::PH_SIZE;
                                end
                            end
                        end
                        yz_pkg::PH_SIZE:
                        begin
                            ds_next = {ds_next[23:0], strm.in_byte};
                            pc_next = pc_next + 4'd1;
                            if (pc_next == 4'd8)
                            begin
                                if (ds_next > MAX_OUTPUT_BYTES)
                                begin
                                    ph_next = yz_pkg::PH_ERR_SIZE;
                                end
                                else
                                begin
                                    if (cap_en_reg && ({1'b0, cap_reg} <= ds_next))
                                    begin
                                        ds_next = {1'b0, cap_reg};
                                    end
                                    ph_next = yz_pkg::PH_RESERVED;
                                end
                            end
                        end
                        yz_pkg::PH_RESERVED:
                        begin
                            pc_next = pc_next + 4'd1;
                            if (pc_next == 4'd0)
                            begin
                                ni = next_item(ps_next, ds_next, gb_next, 4'd0);
                                ph_next = ni.ph;
                                gb_next = ni.gb;
                                gl_next = ni.gl;
                            end
                        end
                        yz_pkg::PH_GROUP:
                        begin
                            ni = next_item(ps_next, ds_next, strm.in_byte, 4'd8);
                            ph_next = ni.ph;
                            gb_next = ni.gb;
                            gl_next = ni.gl;
                        end
                        yz_pkg::PH_LITERAL:
                        begin
                            mreq.wr_en = 1'b1;
                            mreq.wr_addr = ps_next[yz_pkg::WIN_AW-1:0];
                            mreq.wr_data = strm.in_byte;
                            pack_next = {56'd0, strm.in_byte};
                            cnt_next = 4'd1;
                            ps_next = ps_next + 32'd1;
                            ni = next_item(ps_next, ds_next, gb_next, gl_next);
                            ph_next = ni.ph;
                            gb_next = ni.gb;
                            gl_next = ni.gl;
                        end
                        yz_pkg::PH_REF1:
                        begin
                            r1_next = strm.in_byte;
                            ph_next = yz_pkg::PH_REF2;
                        end
                        yz_pkg::PH_REF2:
                        begin
                            r2_next = strm.in_byte;
                            if (r1_next[7:4] == 4'd0)
                            begin
                                ph_next = yz_pkg::PH_REF3;
                            end
                            else
                            begin
                                copy = 1'b1;
                                len = {5'd0, r1_next[7:4]} + {5'd0, yz_pkg::LEN_SHORT_BIAS};
                            end
                        end
                        yz_pkg::PH_REF3:
                        begin
                            copy = 1'b1;
                            len = {1'b0, strm.in_byte} + yz_pkg::LEN_LONG_BIAS;
                        end
                        default:
                        begin
                        end
                    endcase
                    off = {1'b0, r1_next[3:0], r2_next} + 13'd1;
                    if (copy && ({19'd0, off} > ps_next))
                    begin
                        ph_next = yz_pkg::PH_ERR_OFFSET;
                        copy = 1'b0;
                    end
                    case (ph_next)
                        yz_pkg::PH_ERR_MAGIC: st_next = yz_pkg::ST_BAD_MAGIC;
                        yz_pkg::PH_ERR_SIZE: st_next = yz_pkg::ST_SIZE_BIG;
                        yz_pkg::PH_ERR_OFFSET: st_next = yz_pkg::ST_OFFSET;
                        default: st_next = yz_pkg::ST_OK;
                    endcase
                    done_next = (ph_next == yz_pkg::PH_DONE) ||
                                ((ph_next == yz_pkg::PH_RESERVED) && (ps_next >= ds_next));
                    if (copy)
                    begin
                        // copy result: flags known from the final position up front
                        left_next = len;
                        off_next = off;
                        last_next = 1'b0;
                        done_next = ({1'b0, ps_next} + {24'd0, len}) >= {1'b0, ds_next};
                    end
                end
            end
            yz_pkg::E_RD:
            begin
                mreq.rd_en = 1'b1;
                mreq.rd_addr = ps_reg[yz_pkg::WIN_AW-1:0] - off_reg[yz_pkg::WIN_AW-1:0];
            end
            yz_pkg::E_WR:
            begin
                mreq.wr_en = 1'b1;
                mreq.wr_addr = ps_reg[yz_pkg::WIN_AW-1:0];
                mreq.wr_data = rd_data;
                pack_next[cnt_reg[2:0]*8 +: 8] = rd_data;
                cnt_next = cnt_reg + 4'd1;
                ps_next = ps_reg + 32'd1;
                left_next = left_reg - 9'd1;
                if (fin)
                begin
                    last_next = 1'b1;
                    ni = next_item(ps_next, ds_reg, gb_reg, gl_reg);
                    ph_next = ni.ph;
                    gb_next = ni.gb;
                    gl_next = ni.gl;
                end
            end
            yz_pkg::E_EMIT:
            begin
                if (out_free)
                begin
                    ov_next = 1'b1;
                    od_next = pack_reg;
                    oc_next = cnt_reg;
                    ol_next = last_reg;
                    odn_next = done_reg;
                    os_next = st_reg;
                    pack_next = 64'd0;
                    cnt_next = 4'd0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eng_reg <= yz_pkg::E_IDLE;
            ph_reg <= yz_pkg::PH_MAGIC;
            pc_reg <= 4'd0;
            ds_reg <= 32'd0;
            ps_reg <= 32'd0;
            gb_reg <= 8'd0;
            gl_reg <= 4'd0;
            r1_reg <= 8'd0;
            r2_reg <= 8'd0;
            left_reg <= 9'd0;
            cnt_reg <= 4'd0;
            last_reg <= 1'b0;
            ov_reg <= 1'b0;
            cap_en_reg <= 1'b0;
            cap_reg <= 31'd0;
        end
        else
        begin
            eng_reg <= eng_next;
            ph_reg <= ph_next;
            pc_reg <= pc_next;
            ds_reg <= ds_next;
            ps_reg <= ps_next;
            gb_reg <= gb_next;
            gl_reg <= gl_next;
            r1_reg <= r1_next;
            r2_reg <= r2_next;
            left_reg <= left_next;
            cnt_reg <= cnt_next;
            last_reg <= last_next;
            ov_reg <= ov_next;
            if (cfg.valid && (cfg.index == yz_pkg::CFG_CAP_EN))
            begin
                cap_en_reg <= cfg.data[0];
            end
            if (cfg.valid && (cfg.index == yz_pkg::CFG_CAP))
            begin
                cap_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        off_reg <= off_next;
        pack_reg <= pack_next;
        done_reg <= done_next;
        st_reg <= st_next;
        od_reg <= od_next;
        oc_reg <= oc_next;
        ol_reg <= ol_next;
        odn_reg <= odn_next;
        os_reg <= os_next;
    end

endmodule

FILE: design/yz_checker.sv
// port-level checker for the yaz0 decompressor and its bind
`include "assert_macros.svh"

module yz_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [3:0] out_count,
    input logic       out_last,
    input logic [1:0] out_status,
    input logic [63:0] out_data
);

    `ASSERT_IMP(a_count_max, clk, rst_n, out_valid, out_count <= 4'd8)
    `ASSERT_IMP(a_err_empty, clk, rst_n, out_valid && (out_status != yz_pkg::ST_OK), out_count == 4'd0)
    `ASSERT_IMP(a_short_last, clk, rst_n, out_valid && (out_count < 4'd8), out_last)
    `ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

endmodule

bind yaz0_decompressor yz_checker u_chk (
    .clk(clk),
    .rst_n(rst_n),
    .out_valid(dec.valid),
    .out_ready(dec.ready),
    .out_count(dec.out_count),
    .out_last(dec.out_last),
    .out_status(dec.out_status),
    .out_data(dec.out_data)
);

FILE: sim/yz_tb_pkg.sv
// stream word types and decode predictor for the yaz0 decompressor bench
`timescale 1ns / 100ps
package yz_tb_pkg;
    import yz_pkg::*;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_first;
    } strm_word_t;

    typedef struct packed {
        logic [63:0] out_data;
        logic [3:0]  out_count;
        logic        out_last;
        logic        out_done;
        logic [1:0]  out_status;
    } dec_word_t;

    // decoder state mirrored from the block
    typedef struct {
        phase_t      phase;
        logic [3:0]  hdr_cnt;
        logic [31:0] dsize;
        logic [31:0] opos;
        logic [7:0]  gbits;
        logic [3:0]  gleft;
        logic [7:0]  ref_hi;
        logic [7:0]  ref_lo;
        logic [7:0]  hist [WINDOW_BYTES];
        logic        cap_en;
        logic [30:0] cap;
    } dec_state_t;

    // advance to the next token of the current group, to the next group byte, or to done
    function automatic void next_token(ref dec_state_t s);
        if (s.opos >= s.dsize)
            s.phase = PH_DONE;
        else if (s.gleft == 0)
            s.phase = PH_GROUP;
        else
        begin
            s.phase = s.gbits[7] ? PH_LITERAL : PH_REF1;
            s.gbits = s.gbits << 1;
            s.gleft = s.gleft - 1;
        end
    endfunction

    function automatic void put_byte(ref dec_state_t s, ref logic [7:0] bytes[$],
                                     input logic [7:0] b);
        s.hist[s.opos[WIN_AW-1:0]] = b;
        s.opos = s.opos + 1;
        bytes.push_back(b);
    endfunction

    function automatic void copy_back(ref dec_state_t s, ref logic [7:0] bytes[$],
                                      input int unsigned len);
        logic [31:0] span;
        logic [31:0] src;
        span = {20'd0, s.ref_hi[3:0], s.ref_lo} + 32'd1;
        if (span > s.opos)
        begin
            s.phase = PH_ERR_OFFSET;
            return;
        end
        for (int unsigned n = 0; n < len && s.opos < s.dsize; n++)
        begin
            src = s.opos - span;
            put_byte(s, bytes, s.hist[src[WIN_AW-1:0]]);
        end
        next_token(s);
    endfunction

    // predict all words caused by one compressed byte
    function automatic void decode_byte(ref dec_state_t s, input strm_word_t w,
                                        ref dec_word_t res[$]);
        logic [7:0] bytes[$];
        logic [1:0] status;
        logic       done;
        int         nres;
        dec_word_t  r;
        logic [7:0] b;
        b = w.in_byte;
        if (w.in_first)
        begin
            s.phase = PH_MAGIC;
            s.hdr_cnt = 0;
            s.dsize = 0;
            s.opos = 0;
            s.gbits = 0;
            s.gleft = 0;
            s.ref_hi = 0;
            s.ref_lo = 0;
        end
        case (s.phase)
            PH_MAGIC:
            begin
                if (b != magic_byte(s.hdr_cnt[1:0]))
                    s.phase = PH_ERR_MAGIC;
                else
                begin
                    s.hdr_cnt = s.hdr_cnt + 1;
                    if (s.hdr_cnt == 4)
                        s.phase = PH_SIZE;
                end
            end
            PH_SIZE:
            begin
                s.dsize = {s.dsize[23:0], b};
                s.hdr_cnt = s.hdr_cnt + 1;
                if (s.hdr_cnt == 8)
                begin
                    if (s.dsize > MAX_OUTPUT_BYTES_DEF)
                        s.phase = PH_ERR_SIZE;
                    else
                    begin
                        if (s.cap_en && {1'b0, s.cap} <= s.dsize)
                            s.dsize = {1'b0, s.cap};
                        s.phase = PH_RESERVED;
                    end
                end
            end
            PH_RESERVED:
            begin
                s.hdr_cnt = s.hdr_cnt + 1;
                if (s.hdr_cnt == 0)
                begin
                    s.gleft = 0;
                    next_token(s);
                end
            end
            PH_GROUP:
            begin
                s.gbits = b;
                s.gleft = 8;
                next_token(s);
            end
            PH_LITERAL:
            begin
                put_byte(s, bytes, b);
                next_token(s);
            end
            PH_REF1:
            begin
                s.ref_hi = b;
                s.phase = PH_REF2;
            end
            PH_REF2:
            begin
                s.ref_lo = b;
                if (s.ref_hi[7:4] == 0)
                    s.phase = PH_REF3;
                else
                    copy_back(s, bytes, 32'(s.ref_hi[7:4]) + 32'(LEN_SHORT_BIAS));
            end
            PH_REF3:
                copy_back(s, bytes, 32'(b) + 32'(LEN_LONG_BIAS));
            default: ;
        endcase
        case (s.phase)
            PH_ERR_MAGIC: status = ST_BAD_MAGIC;
            PH_ERR_SIZE: status = ST_SIZE_BIG;
            PH_ERR_OFFSET: status = ST_OFFSET;
            default: status = ST_OK;
        endcase
        done = s.phase == PH_DONE || (s.phase == PH_RESERVED && s.opos >= s.dsize);
        nres = bytes.size() == 0 ? 1 : (bytes.size() + 7) / 8;
        for (int k = 0; k < nres; k++)
        begin
            r = '0;
            for (int i = 0; i < 8; i++)
                if (k * 8 + i < bytes.size())
                begin
                    r.out_data[8*i +: 8] = bytes[k*8 + i];
                    r.out_count = r.out_count + 1;
                end
            r.out_last = k == nres - 1;
            r.out_done = done;
            r.out_status = status;
            res.push_back(r);
        end
    endfunction
endpackage

FILE: sim/testbench.sv
// self-checking testbench of the yaz0 decompressor
`timescale 1ns / 100ps
module testbench;
    import yz_pkg::*;
    import yz_tb_pkg::*;

    logic clk = 0;
    logic rst_n = 0;

    yz_in_if strm();
    yz_out_if dec();
    yz_cfg_if cfg();

    yaz0_decompressor dut (.clk(clk), .rst_n(rst_n), .strm(strm), .dec(dec), .cfg(cfg));

    always #6 clk = ~clk;

    dec_state_t model;
    dec_word_t  pending_words[$];
    int         fail_count = 0;
    int         words_seen = 0;
    int         bytes_sent = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         hold_off_cycles = 0;

    initial
    begin
        strm.valid = 0;
        strm.in_byte = 0;
        strm.in_first = 0;
        dec.ready = 0;
        cfg.valid = 0;
        cfg.index = CFG_CAP_EN;
        cfg.data = 0;
    end

    // receiver: random stalls, plus long hold-offs on request
    always @(negedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            dec.ready <= 0;
            hold_off_cycles <= hold_off_cycles - 1;
        end
        else
            dec.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    // compare every accepted word with the oldest prediction
    always @(posedge clk)
    begin
        dec_word_t got;
        dec_word_t want;
        if (rst_n && dec.valid && dec.ready)
        begin
            got = {dec.out_data, dec.out_count, dec.out_last, dec.out_done, dec.out_status};
            words_seen++;
            if (pending_words.size() == 0)
            begin
                $error("unexpected word data=%h", got.out_data);
                fail_count++;
            end
            else
            begin
                want = pending_words.pop_front();
                if (got.out_data !== want.out_data)
                begin
                    $error("out_data exp %h got %h", want.out_data, got.out_data);
                    fail_count++;
                end
                if (got.out_count !== want.out_count)
                begin
                    $error("out_count exp %0d got %0d", want.out_count, got.out_count);
                    fail_count++;
                end
                if (got.out_last !== want.out_last)
                begin
                    $error("out_last exp %0d got %0d", want.out_last, got.out_last);
                    fail_count++;
                end
                if (got.out_done !== want.out_done)
                begin
                    $error("out_done exp %0d got %0d", want.out_done, got.out_done);
                    fail_count++;
                end
                if (got.out_status !== want.out_status)
                begin
                    $error("out_status exp %0d got %0d", want.out_status, got.out_status);
                    fail_count++;
                end
            end
        end
    end

    // send one compressed byte, predicting its words at acceptance
    // valid stays up after acceptance until the next falling edge decides
    task automatic send_byte(input logic [7:0] b, input logic first = 0);
        strm_word_t w;
        w = {b, first};
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            strm.valid <= 0;
            @(negedge clk);
        end
        strm.valid <= 1;
        strm.in_byte <= b;
        strm.in_first <= first;
        @(posedge clk);
        while (!strm.ready)
            @(posedge clk);
        decode_byte(model, w, pending_words);
        bytes_sent++;
    endtask

    task automatic drain();
        int guard;
        @(negedge clk);
        strm.valid <= 0;
        guard = 0;
        while (pending_words.size() != 0 && guard < 200000)
        begin
            @(negedge clk);
            guard++;
        end
        // every byte yields a word; this wait only adds idle time after the queue empties
        repeat (600) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [30:0] v);
        drain();
        cfg.valid <= 1;
        cfg.index <= idx;
        cfg.data <= v;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        if (idx == CFG_CAP_EN)
            model.cap_en = v[0];
        else
            model.cap = v;
        @(negedge clk);
        cfg.valid <= 0;
    endtask

    task automatic send_header(input logic [31:0] size, input logic [7:0] rsv = 8'h00);
        send_byte(8'h59, 1);
        send_byte(8'h61);
        send_byte(8'h7A);
        send_byte(8'h30);
        for (int i = 3; i >= 0; i--)
            send_byte(size[8*i +: 8]);
        for (int i = 0; i < 8; i++)
            send_byte(rsv ^ 8'(i * 37));
    endtask

    // well-formed random stream with literals and back-references
    task automatic send_random_stream(input int n_groups, input logic long_refs);
        logic [31:0] made;
        logic [7:0]  g;
        int unsigned span;
        int unsigned len;
        made = 0;
        send_header($urandom_range(1, 12) * 40, 8'($urandom));
        for (int gi = 0; gi < n_groups; gi++)
        begin
            g = $urandom;
            if (made == 0)
                g[7] = 1;
            send_byte(g);
            for (int t = 0; t < 8; t++)
            begin
                if (g[7 - t] || made < 2)
                begin
                    send_byte($urandom);
                    made++;
                end
                else
                begin
                    span = $urandom_range(1, made > 4096 ? 4096 : made);
                    len = (long_refs && $urandom_range(3) == 0) ?
                          $urandom_range(18, 273) : $urandom_range(2, 17);
                    if (len >= 18)
                    begin
                        send_byte({4'h0, 4'((span - 1) >> 8)});
                        send_byte(8'(span - 1));
                        send_byte(8'(len - 18));
                    end
                    else
                    begin
                        send_byte({4'(len - 2), 4'((span - 1) >> 8)});
                        send_byte(8'(span - 1));
                    end
                    made += len;
                end
            end
        end
    endtask

    task automatic test_directed();
        // zero size: done right after size bytes
        send_header(0, 8'hFF);
        send_byte(8'hFF);
        // bad magic, then stays in error
        send_byte(8'h59, 1);
        send_byte(8'h00);
        send_byte(8'h59);
        // size too large
        send_byte(8'h59, 1);
        send_byte(8'h61);
        send_byte(8'h7A);
        send_byte(8'h30);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'h00);
        // literal, long copy past size, offset before start
        send_header(32'd20);
        send_byte(8'h80);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hAA);
        send_header(32'd300);
        send_byte(8'h40);
        send_byte(8'hF0);
        send_byte(8'h00);
        send_byte(8'h0F);
        send_byte(8'hFF);
        send_byte(8'h00);
    endtask

    task automatic test_size_cap();
        write_reg(CFG_CAP, 31'h7FFFFFFF);
        write_reg(CFG_CAP_EN, 1);
        send_random_stream(1, 1);
        write_reg(CFG_CAP, 31'd0);
        send_random_stream(1, 0);
        write_reg(CFG_CAP, 31'd13);
        send_random_stream(1, 1);
        write_reg(CFG_CAP_EN, 0);
    endtask

    task automatic test_random(input int idle, input int stall, input int nbytes);
        int start;
        send_idle_pct = idle;
        recv_stall_pct = stall;
        start = bytes_sent;
        while (bytes_sent - start < nbytes)
        begin
            if ($urandom_range(9) == 0)
                send_byte($urandom, $urandom_range(1));
            else
                send_random_stream(1, $urandom_range(1));
        end
        drain();
    endtask

    task automatic test_pressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        @(negedge clk);
        hold_off_cycles = 400;
        send_random_stream(2, 1);
        drain();
    endtask

    initial
    begin
        for (int i = 0; i < WINDOW_BYTES; i++)
            model.hist[i] = 0;
        model.phase = PH_MAGIC;
        model.hdr_cnt = 0;
        model.dsize = 0;
        model.opos = 0;
        model.gbits = 0;
        model.gleft = 0;
        model.ref_hi = 0;
        model.ref_lo = 0;
        model.cap_en = 0;
        model.cap = 0;
        repeat (6) @(negedge clk);
        rst_n = 1;
        @(negedge clk);
        test_directed();
        test_size_cap();
        test_random(0, 0, 10);
        test_random(73, 0, 10);
        test_random(0, 73, 10);
        test_random(27, 27, 10);
        test_pressure();
        repeat (50) @(negedge clk);
        $display("sent %0d compressed bytes, checked %0d decoded words", bytes_sent,
                 words_seen);
        $display("covered header errors, size cap, long copies and idle/stall phases");
        if (fail_count == 0 && pending_words.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #30ms;
        $display("Test completed with failures");
        $finish;
    end
endmodule
